### src/tag_access_table_macros.svh
// assertion macros shared by the tag access table rtl
`ifndef TAG_ACCESS_TABLE_MACROS_SVH
`define TAG_ACCESS_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define TAT_ASSERT_HOLD(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tag_access_table: invariant violated");
// next-cycle implication, checked out of reset
`define TAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tag_access_table: sequencing violated");
`else
`define TAT_ASSERT_HOLD(lbl, clk, rst_n, ante, cons)
`define TAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### src/tat_pkg.sv
// shared types, codes and defaults for the tag access table
package tat_pkg;

  // fixed field widths
  localparam int CMD_W        = 3;
  localparam int UID_FIELD_W  = 56;
  localparam int LEN_W        = 3;
  localparam int NAME_FIELD_W = 64;
  localparam int ZONE_W       = 2;
  localparam int STATUS_W     = 4;
  localparam int ACTION_W     = 2;
  localparam int SLOT_W       = 4;
  localparam int TICK_W       = 16;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;
  localparam int REG_SEL_BIT  = 2;

  // parameter defaults
  localparam int DEF_TABLE_ENTRIES = 16;
  localparam int DEF_UID_MAX_BYTES = 7;
  localparam int DEF_NAME_CHARS    = 8;
  localparam int DEF_ENTRY_W       = 8 * 7 + LEN_W + 8 * DEF_NAME_CHARS + ZONE_W;

  // command codes
  localparam logic [CMD_W-1:0] CMD_SCAN   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POLL   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ENROLL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_IDLE        = 4'd0;
  localparam logic [STATUS_W-1:0] ST_REPEAT      = 4'd1;
  localparam logic [STATUS_W-1:0] ST_ENROLLED    = 4'd2;
  localparam logic [STATUS_W-1:0] ST_UPDATED     = 4'd3;
  localparam logic [STATUS_W-1:0] ST_FULL        = 4'd4;
  localparam logic [STATUS_W-1:0] ST_GRANTED     = 4'd5;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN     = 4'd6;
  localparam logic [STATUS_W-1:0] ST_ARMED       = 4'd7;
  localparam logic [STATUS_W-1:0] ST_DELETED     = 4'd8;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 4'd9;
  localparam logic [STATUS_W-1:0] ST_RELOCK      = 4'd10;
  localparam logic [STATUS_W-1:0] ST_RELOCK_DROP = 4'd11;

  // zone and door action codes
  localparam logic [ZONE_W-1:0]   ZONE_MOTION = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_UNLOCK  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOCK    = 2'd2;

  // register indexes and reset values
  localparam logic REG_ENROLL_WINDOW = 1'b0;
  localparam logic REG_RELOCK_DELAY  = 1'b1;
  localparam logic [TICK_W-1:0] TICK_RESET = 16'd5;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [UID_FIELD_W-1:0]  tag_uid;
    logic [LEN_W-1:0]        tag_uid_bytes;
    logic [NAME_FIELD_W-1:0] tag_name;
    logic [ZONE_W-1:0]       tag_zone;
    logic                    link_up;
  } tat_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [NAME_FIELD_W-1:0] out_name;
    logic [ZONE_W-1:0]       out_zone;
    logic [ACTION_W-1:0]     door_action;
    logic                    publish_now;
    logic [SLOT_W-1:0]       slot_index;
  } tat_out_t;

  // write-side controls of the entry store
  typedef struct packed {
    logic wr_entry;
    logic set_valid;
    logic clr_valid;
  } tat_wr_ctl_t;

endpackage

### src/tat_store.sv
// entry store: one synchronous memory for the entries plus per-slot valid flags
module tat_store import tat_pkg::*; #(
  parameter int DEPTH  = DEF_TABLE_ENTRIES,
  parameter int DATA_W = DEF_ENTRY_W,
  parameter int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [DATA_W-1:0] rd_data_r,
  output logic              rd_valid_r,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  tat_wr_ctl_t       wr_ctl
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0]  valid_r;

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (wr_ctl.wr_entry) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // valid flags, cleared at reset, read alongside the entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_ctl.set_valid) begin
        valid_r[wr_addr] <= 1'b1;
      end else if (wr_ctl.clr_valid) begin
        valid_r[wr_addr] <= 1'b0;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

endmodule

### src/tag_access_table.sv
// top level of the tag access table: event decode, table walk and result register
//
// Takes one event at a time (scan, empty poll, enroll, delete, tick) and returns one
// result per event. Scans and deletes walk the entry store one slot per cycle through
// its single read port until a match or the last slot ends the walk; polls, enroll
// requests, repeated scans and ticks go straight to the result. A finished result
// sits in an output register, and the block takes the next event while it waits
// there; a new result waits for that register to drain. The store needs no
// clearing pass after reset: only the per-slot valid flags are cleared.
module tag_access_table import tat_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int UID_MAX_BYTES = DEF_UID_MAX_BYTES,
  parameter int NAME_CHARS    = DEF_NAME_CHARS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tat_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tat_out_t              out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

`include "tag_access_table_macros.svh"

  localparam int IDX_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int UID_KEPT = (UID_MAX_BYTES < 7) ? UID_MAX_BYTES : 7;
  localparam int UID_W    = 8 * UID_KEPT;
  localparam int NAME_W   = 8 * NAME_CHARS;
  localparam int DATA_W   = UID_W + LEN_W + NAME_W + ZONE_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [LEN_W-1:0] LEN_CAP  = LEN_W'(UID_KEPT);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  // walk modes
  localparam logic [1:0] M_LOOKUP = 2'd0;
  localparam logic [1:0] M_ENROLL = 2'd1;
  localparam logic [1:0] M_DELETE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [1:0] mode_r, mode_nxt;

  // latched event
  logic [CMD_W-1:0]  cmd_r;
  logic [UID_W-1:0]  uid_r;
  logic [LEN_W-1:0]  len_r;
  logic [NAME_W-1:0] name_r;
  logic [ZONE_W-1:0] zone_r;
  logic              link_r;

  // last scan, enrollment window, relock countdown, config
  logic [UID_W-1:0]  last_uid_r, last_uid_nxt;
  logic [LEN_W-1:0]  last_len_r, last_len_nxt;
  logic              enr_act_r, enr_act_nxt;
  logic [NAME_W-1:0] enr_name_r, enr_name_nxt;
  logic [ZONE_W-1:0] enr_zone_r, enr_zone_nxt;
  logic [TICK_W-1:0] enr_rem_r, enr_rem_nxt;
  logic              rlk_act_r, rlk_act_nxt;
  logic [ZONE_W-1:0] rlk_zone_r, rlk_zone_nxt;
  logic [TICK_W-1:0] rlk_rem_r, rlk_rem_nxt;
  logic [TICK_W-1:0] win_ticks_r, win_ticks_nxt;
  logic [TICK_W-1:0] dly_ticks_r, dly_ticks_nxt;

  // walk bookkeeping
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic              chk_pend_r, chk_pend_nxt;
  logic              free_fnd_r, free_fnd_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;

  // result staging and output register
  tat_out_t          res_r, res_nxt;
  tat_out_t          out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;

  // store port signals
  logic              rd_en;
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_valid_r;
  logic [IDX_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;
  tat_wr_ctl_t       wr_ctl;

  // input masking
  logic [LEN_W-1:0]  len_cut;
  logic [UID_W-1:0]  uid_in_m;
  logic              in_xfer;
  logic              cfg_wr;

  // entry fields and compare results
  logic [ZONE_W-1:0] e_zone;
  logic [NAME_W-1:0] e_name;
  logic [LEN_W-1:0]  e_len;
  logic [UID_W-1:0]  e_uid;
  logic [NAME_W-1:0] tgt_name;
  logic [ZONE_W-1:0] tgt_zone;
  logic              match_uid, match_name, hit, last_chk;
  logic              free_here, free_ok;
  logic [IDX_W-1:0]  free_at;

  tat_store #(
    .DEPTH  (TABLE_ENTRIES),
    .DATA_W (DATA_W),
    .IDX_W  (IDX_W)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (rd_en),
    .rd_addr    (rd_idx_r),
    .rd_data_r  (rd_data_r),
    .rd_valid_r (rd_valid_r),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .wr_ctl     (wr_ctl)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;

  // register readback
  always_comb begin
    unique case (paddr[REG_SEL_BIT])
      REG_ENROLL_WINDOW: prdata = APB_DATA_W'(win_ticks_r);
      REG_RELOCK_DELAY:  prdata = APB_DATA_W'(dly_ticks_r);
      default:           prdata = '0;
    endcase
  end

  // clip length and zero identifier bytes beyond it
  assign len_cut = (in_data.tag_uid_bytes > LEN_CAP) ? LEN_CAP : in_data.tag_uid_bytes;
  always_comb begin
    for (int b = 0; b < UID_KEPT; b++) begin
      uid_in_m[8*b +: 8] = (LEN_W'(b) < len_cut) ? in_data.tag_uid[8*b +: 8] : 8'h00;
    end
  end

  // unpack the entry read last cycle and compare it
  assign e_zone     = rd_data_r[ZONE_W-1:0];
  assign e_name     = rd_data_r[ZONE_W +: NAME_W];
  assign e_len      = rd_data_r[ZONE_W+NAME_W +: LEN_W];
  assign e_uid      = rd_data_r[ZONE_W+NAME_W+LEN_W +: UID_W];
  assign tgt_name   = (mode_r == M_ENROLL) ? enr_name_r : name_r;
  assign tgt_zone   = (mode_r == M_ENROLL) ? enr_zone_r : zone_r;
  assign match_uid  = rd_valid_r && (e_len == len_r) && (e_uid == uid_r);
  assign match_name = rd_valid_r && (e_name == tgt_name) && (e_zone == tgt_zone);
  assign hit        = (mode_r == M_LOOKUP) ? match_uid : match_name;
  assign last_chk   = (chk_idx_r == LAST_IDX);
  assign free_here  = !rd_valid_r && !free_fnd_r;
  assign free_ok    = free_fnd_r || free_here;
  assign free_at    = free_fnd_r ? free_idx_r : chk_idx_r;

  // sequencer and state update
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    last_uid_nxt  = last_uid_r;
    last_len_nxt  = last_len_r;
    enr_act_nxt   = enr_act_r;
    enr_name_nxt  = enr_name_r;
    enr_zone_nxt  = enr_zone_r;
    enr_rem_nxt   = enr_rem_r;
    rlk_act_nxt   = rlk_act_r;
    rlk_zone_nxt  = rlk_zone_r;
    rlk_rem_nxt   = rlk_rem_r;
    win_ticks_nxt = win_ticks_r;
    dly_ticks_nxt = dly_ticks_r;
    rd_idx_nxt    = rd_idx_r;
    chk_idx_nxt   = chk_idx_r;
    chk_pend_nxt  = chk_pend_r;
    free_fnd_nxt  = free_fnd_r;
    free_idx_nxt  = free_idx_r;
    res_nxt       = res_r;
    out_load      = 1'b0;
    rd_en         = 1'b0;
    wr_ctl        = '0;
    wr_addr       = chk_idx_r;
    wr_data       = {uid_r, len_r, enr_name_r, enr_zone_r};

    // config writes
    if (cfg_wr) begin
      unique case (paddr[REG_SEL_BIT])
        REG_ENROLL_WINDOW: win_ticks_nxt = pwdata[TICK_W-1:0];
        REG_RELOCK_DELAY:  dly_ticks_nxt = pwdata[TICK_W-1:0];
        default:           win_ticks_nxt = win_ticks_r;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        res_nxt   = '0;
        state_nxt = S_EMIT;
        unique case (cmd_r)
          CMD_SCAN: begin
            if ((len_r == last_len_r) && (uid_r == last_uid_r)) begin
              res_nxt.status = ST_REPEAT;
            end else begin
              last_uid_nxt = uid_r;
              last_len_nxt = len_r;
              rd_idx_nxt   = '0;
              chk_pend_nxt = 1'b0;
              free_fnd_nxt = 1'b0;
              state_nxt    = S_WALK;
              if (enr_act_r) begin
                enr_act_nxt = 1'b0;
                enr_rem_nxt = '0;
                mode_nxt    = M_ENROLL;
              end else begin
                mode_nxt = M_LOOKUP;
              end
            end
          end
          CMD_POLL: begin
            last_len_nxt = '0;
          end
          CMD_ENROLL: begin
            enr_name_nxt     = name_r;
            enr_zone_nxt     = zone_r;
            enr_act_nxt      = 1'b1;
            enr_rem_nxt      = win_ticks_r;
            res_nxt.status   = ST_ARMED;
            res_nxt.out_name = NAME_FIELD_W'(name_r);
            res_nxt.out_zone = zone_r;
          end
          CMD_DELETE: begin
            rd_idx_nxt   = '0;
            chk_pend_nxt = 1'b0;
            free_fnd_nxt = 1'b0;
            mode_nxt     = M_DELETE;
            state_nxt    = S_WALK;
          end
          CMD_TICK: begin
            // enrollment window closes silently
            if (enr_act_r) begin
              if (enr_rem_r <= TICK_W'(1)) begin
                enr_rem_nxt = '0;
                enr_act_nxt = 1'b0;
              end else begin
                enr_rem_nxt = enr_rem_r - 1'b1;
              end
            end
            // relock expiry reports
            if (rlk_act_r) begin
              if (rlk_rem_r <= TICK_W'(1)) begin
                rlk_rem_nxt      = '0;
                rlk_act_nxt      = 1'b0;
                res_nxt.out_zone = rlk_zone_r;
                if (link_r) begin
                  res_nxt.status = ST_RELOCK;
                  if (rlk_zone_r != ZONE_MOTION) begin
                    res_nxt.door_action = ACT_LOCK;
                    res_nxt.publish_now = 1'b1;
                  end
                end else begin
                  res_nxt.status = ST_RELOCK_DROP;
                end
              end else begin
                rlk_rem_nxt = rlk_rem_r - 1'b1;
              end
            end
          end
          default: begin
            res_nxt = '0;
          end
        endcase
      end

      S_WALK: begin
        // issue one read a cycle, check the one read last cycle
        rd_en        = 1'b1;
        chk_pend_nxt = 1'b1;
        chk_idx_nxt  = rd_idx_r;
        if (rd_idx_r != LAST_IDX) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (chk_pend_r) begin
          if (free_here) begin
            free_fnd_nxt = 1'b1;
            free_idx_nxt = chk_idx_r;
          end
          if (hit || last_chk) begin
            state_nxt    = S_EMIT;
            chk_pend_nxt = 1'b0;
            res_nxt      = '0;
            case (mode_r)
              M_LOOKUP: begin
                res_nxt.publish_now = link_r;
                if (hit) begin
                  res_nxt.status     = ST_GRANTED;
                  res_nxt.out_name   = NAME_FIELD_W'(e_name);
                  res_nxt.out_zone   = e_zone;
                  res_nxt.slot_index = SLOT_W'(chk_idx_r);
                  if (link_r) begin
                    rlk_act_nxt  = 1'b1;
                    rlk_zone_nxt = e_zone;
                    rlk_rem_nxt  = dly_ticks_r;
                    if (e_zone != ZONE_MOTION) begin
                      res_nxt.door_action = ACT_UNLOCK;
                    end
                  end
                end else begin
                  res_nxt.status = ST_UNKNOWN;
                end
              end
              M_ENROLL: begin
                res_nxt.out_name = NAME_FIELD_W'(enr_name_r);
                res_nxt.out_zone = enr_zone_r;
                if (hit) begin
                  wr_ctl.wr_entry    = 1'b1;
                  res_nxt.status     = ST_UPDATED;
                  res_nxt.slot_index = SLOT_W'(chk_idx_r);
                end else if (free_ok) begin
                  wr_addr            = free_at;
                  wr_ctl.wr_entry    = 1'b1;
                  wr_ctl.set_valid   = 1'b1;
                  res_nxt.status     = ST_ENROLLED;
                  res_nxt.slot_index = SLOT_W'(free_at);
                end else begin
                  res_nxt.status = ST_FULL;
                end
              end
              default: begin
                res_nxt.out_name = NAME_FIELD_W'(name_r);
                res_nxt.out_zone = zone_r;
                if (hit) begin
                  wr_ctl.clr_valid   = 1'b1;
                  res_nxt.status     = ST_DELETED;
                  res_nxt.slot_index = SLOT_W'(chk_idx_r);
                end else begin
                  res_nxt.status = ST_NOT_FOUND;
                end
              end
            endcase
          end
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  assign out_nxt       = out_load ? res_r : out_r;
  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= M_LOOKUP;
      last_uid_r  <= '0;
      last_len_r  <= '0;
      enr_act_r   <= 1'b0;
      enr_name_r  <= '0;
      enr_zone_r  <= '0;
      enr_rem_r   <= '0;
      rlk_act_r   <= 1'b0;
      rlk_zone_r  <= '0;
      rlk_rem_r   <= '0;
      win_ticks_r <= TICK_RESET;
      dly_ticks_r <= TICK_RESET;
      rd_idx_r    <= '0;
      chk_idx_r   <= '0;
      chk_pend_r  <= 1'b0;
      free_fnd_r  <= 1'b0;
      free_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      last_uid_r  <= last_uid_nxt;
      last_len_r  <= last_len_nxt;
      enr_act_r   <= enr_act_nxt;
      enr_name_r  <= enr_name_nxt;
      enr_zone_r  <= enr_zone_nxt;
      enr_rem_r   <= enr_rem_nxt;
      rlk_act_r   <= rlk_act_nxt;
      rlk_zone_r  <= rlk_zone_nxt;
      rlk_rem_r   <= rlk_rem_nxt;
      win_ticks_r <= win_ticks_nxt;
      dly_ticks_r <= dly_ticks_nxt;
      rd_idx_r    <= rd_idx_nxt;
      chk_idx_r   <= chk_idx_nxt;
      chk_pend_r  <= chk_pend_nxt;
      free_fnd_r  <= free_fnd_nxt;
      free_idx_r  <= free_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r  <= in_data.cmd;
      uid_r  <= uid_in_m;
      len_r  <= len_cut;
      name_r <= in_data.tag_name[NAME_W-1:0];
      zone_r <= in_data.tag_zone;
      link_r <= in_data.link_up;
    end
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  // checks
  `TAT_ASSERT_NEXT(a_walk_ends_at_last, clk, rst_n, (state_r == S_WALK) && chk_pend_r && last_chk, state_r == S_EMIT)
  `TAT_ASSERT_HOLD(a_enroll_idle_zero, clk, rst_n, !enr_act_r, enr_rem_r == '0)
  `TAT_ASSERT_HOLD(a_relock_idle_zero, clk, rst_n, !rlk_act_r, rlk_rem_r == '0)
  `TAT_ASSERT_NEXT(a_one_event_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule
